// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL. Both sample on clk_i and are held off
// while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mtws_pkg.sv =====
package mtws_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned OUT_W       = 26;
  localparam int unsigned MAX_LEN_DEF = 1024;
  localparam int unsigned RES_DEPTH   = 8;

  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_LEN  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_LEN = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] best_sum;
    logic                    too_short;
  } out_t;

  // Per-sample control that travels down the pipeline with each transaction.
  typedef struct packed {
    logic vld;
    logic last;
    logic fits;
    logic past;
    logic at_total;
  } ctl_t;

endpackage

// ===== hdl/mtws_ram.sv =====
module mtws_ram #(
  parameter int unsigned WIDTH    = mtws_pkg::SAMPLE_W,
  parameter int unsigned DEPTH    = mtws_pkg::MAX_LEN_DEF,
  parameter int unsigned RD_PORTS = 2,
  localparam int unsigned AW      = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    rd_addr_i [RD_PORTS],
  output logic [WIDTH-1:0] rd_data_o [RD_PORTS]
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q  [RD_PORTS];

  // Read-first: a read of the entry being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    for (int p = 0; p < RD_PORTS; p++) begin
      rd_q[p] <= mem_q[rd_addr_i[p]];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hdl/mtws_window.sv =====
module mtws_window #(
  parameter int unsigned MAX_LEN = mtws_pkg::MAX_LEN_DEF,
  parameter int unsigned SUM_W   = mtws_pkg::SAMPLE_W + $clog2(mtws_pkg::MAX_LEN_DEF)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  mtws_pkg::in_t                 in_i,
  input  logic [mtws_pkg::LEN_W-1:0]    first_len_i,
  input  logic [mtws_pkg::LEN_W-1:0]    second_len_i,
  output mtws_pkg::ctl_t                ctl_o,
  output logic signed [SUM_W-1:0]       fs_now_o,
  output logic signed [SUM_W-1:0]       ss_now_o,
  output logic signed [SUM_W-1:0]       fs_lag_o,
  output logic signed [SUM_W-1:0]       ss_lag_o
);

  localparam int unsigned AW      = $clog2(MAX_LEN);
  localparam int unsigned CNT_W   = $clog2(2 * MAX_LEN);
  localparam int unsigned LW      = mtws_pkg::LEN_W;
  localparam int unsigned SW      = mtws_pkg::SAMPLE_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2 * MAX_LEN - 1);

  logic [AW-1:0]    wpos_q, wpos_nxt;
  logic [CNT_W-1:0] cnt_q;

  logic [LW-1:0]    len_l, len_m;
  logic [LW:0]      len_t;
  logic             fits, v_l, v_m, v_t;
  mtws_pkg::ctl_t   p1_ctl_d, p1_ctl_q, ctl2_q;

  logic [AW-1:0]    rd_addr_a [2];
  logic [AW-1:0]    rd_addr_b [1];
  logic [SW-1:0]    rd_a [2];
  logic [SW-1:0]    rd_b [1];

  logic signed [SW-1:0] p1_x_q;
  logic                 p1_vl_q, p1_vm_q, p1_vt_q;

  logic signed [SUM_W-1:0] fs_q, ss_q, fl_q, sl_q;
  logic signed [SUM_W-1:0] fs_d, ss_d, fl_d, sl_d;
  logic signed [SUM_W-1:0] fs2_q, ss2_q, fl2_q, sl2_q;
  logic signed [SUM_W-1:0] x_s, bl_s, bm_s, bt_s;

  // Stage 1: lengths, gates and history addresses for the incoming sample.
  always_comb begin
    len_l = (first_len_i == '0) ? LW'(1) : first_len_i;
    len_m = (second_len_i == '0) ? LW'(1) : second_len_i;
    len_t = {1'b0, len_l} + {1'b0, len_m};
    fits  = 32'(len_t) <= MAX_LEN;
    v_l   = 32'(cnt_q) >= 32'(len_l);
    v_m   = 32'(cnt_q) >= 32'(len_m);
    v_t   = 32'(cnt_q) >= 32'(len_t);

    p1_ctl_d.vld      = acc_i;
    p1_ctl_d.last     = in_i.last;
    p1_ctl_d.fits     = fits;
    p1_ctl_d.past     = 32'(cnt_q) + 32'd1 >= 32'(len_t);
    p1_ctl_d.at_total = 32'(cnt_q) + 32'd1 == 32'(len_t);

    wpos_nxt = (32'(wpos_q) == MAX_LEN - 1) ? '0 : wpos_q + AW'(1);
  end

  always_comb begin
    int a_l, a_m, a_t;
    a_l = int'(wpos_q) - int'(len_l);
    a_m = int'(wpos_q) - int'(len_m);
    a_t = int'(wpos_q) - int'(len_t);
    if (a_l < 0) a_l = a_l + int'(MAX_LEN);
    if (a_m < 0) a_m = a_m + int'(MAX_LEN);
    if (a_t < 0) a_t = a_t + int'(MAX_LEN);
    rd_addr_a[0] = AW'(a_l);
    rd_addr_a[1] = AW'(a_m);
    rd_addr_b[0] = AW'(a_t);
  end

  // Two copies of the history: one serves the two window lengths, the other
  // the combined length.
  mtws_ram #(
    .WIDTH   (SW),
    .DEPTH   (MAX_LEN),
    .RD_PORTS(2)
  ) u_hist_a (
    .clk_i    (clk_i),
    .we_i     (acc_i & fits),
    .waddr_i  (wpos_q),
    .wdata_i  (in_i.sample),
    .rd_addr_i(rd_addr_a),
    .rd_data_o(rd_a)
  );

  mtws_ram #(
    .WIDTH   (SW),
    .DEPTH   (MAX_LEN),
    .RD_PORTS(1)
  ) u_hist_b (
    .clk_i    (clk_i),
    .we_i     (acc_i & fits),
    .waddr_i  (wpos_q),
    .wdata_i  (in_i.sample),
    .rd_addr_i(rd_addr_b),
    .rd_data_o(rd_b)
  );

  // Stage 2: advance the running window sums.
  always_comb begin
    x_s  = SUM_W'(p1_x_q);
    bl_s = p1_vl_q ? SUM_W'(signed'(rd_a[0])) : '0;
    bm_s = p1_vm_q ? SUM_W'(signed'(rd_a[1])) : '0;
    bt_s = p1_vt_q ? SUM_W'(signed'(rd_b[0])) : '0;
    fs_d = fs_q;
    ss_d = ss_q;
    fl_d = fl_q;
    sl_d = sl_q;
    if (p1_ctl_q.fits) begin
      fs_d = fs_q + x_s - bl_s;
      ss_d = ss_q + x_s - bm_s;
      if (p1_vm_q) fl_d = fl_q + bm_s - bt_s;
      if (p1_vl_q) sl_d = sl_q + bl_s - bt_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= '0;
      cnt_q    <= '0;
      p1_ctl_q <= '0;
      ctl2_q   <= '0;
      fs_q     <= '0;
      ss_q     <= '0;
      fl_q     <= '0;
      sl_q     <= '0;
    end else begin
      p1_ctl_q <= p1_ctl_d;
      ctl2_q   <= p1_ctl_q;
      if (acc_i) begin
        if (in_i.last) begin
          wpos_q <= '0;
          cnt_q  <= '0;
        end else begin
          if (fits) wpos_q <= wpos_nxt;
          if (cnt_q != CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (p1_ctl_q.vld) begin
        if (p1_ctl_q.last) begin
          fs_q <= '0;
          ss_q <= '0;
          fl_q <= '0;
          sl_q <= '0;
        end else begin
          fs_q <= fs_d;
          ss_q <= ss_d;
          fl_q <= fl_d;
          sl_q <= sl_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      p1_x_q  <= in_i.sample;
      p1_vl_q <= v_l;
      p1_vm_q <= v_m;
      p1_vt_q <= v_t;
    end
    fs2_q <= fs_d;
    ss2_q <= ss_d;
    fl2_q <= fl_d;
    sl2_q <= sl_d;
  end

  assign ctl_o    = ctl2_q;
  assign fs_now_o = fs2_q;
  assign ss_now_o = ss2_q;
  assign fs_lag_o = fl2_q;
  assign ss_lag_o = sl2_q;

endmodule

// ===== hdl/mtws_best.sv =====
module mtws_best #(
  parameter int unsigned SUM_W = mtws_pkg::SAMPLE_W + $clog2(mtws_pkg::MAX_LEN_DEF)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mtws_pkg::ctl_t          ctl_i,
  input  logic signed [SUM_W-1:0] fs_now_i,
  input  logic signed [SUM_W-1:0] ss_now_i,
  input  logic signed [SUM_W-1:0] fs_lag_i,
  input  logic signed [SUM_W-1:0] ss_lag_i,
  output logic                    res_vld_o,
  output mtws_pkg::out_t          res_o
);

  localparam int unsigned TOT_W = SUM_W + 1;

  logic                    upd3, upd5, short5;
  logic signed [SUM_W-1:0] bf_q, bs_q, bf_d, bs_d;
  mtws_pkg::ctl_t          ctl3_q, ctl4_q;
  logic signed [SUM_W-1:0] bf3_q, bs3_q, fs3_q, ss3_q;
  logic signed [TOT_W-1:0] c1, c2, c4_q, bt_q, bt_d;

  // Stage 3: running maxima of the earlier windows.
  always_comb begin
    upd3 = ctl_i.vld & ctl_i.fits & ctl_i.past;
    bf_d = bf_q;
    bs_d = bs_q;
    if (upd3) begin
      if (ctl_i.at_total) begin
        bf_d = fs_lag_i;
        bs_d = ss_lag_i;
      end else begin
        if (fs_lag_i > bf_q) bf_d = fs_lag_i;
        if (ss_lag_i > bs_q) bs_d = ss_lag_i;
      end
    end
  end

  // Stage 4: best pairing in either order.
  always_comb begin
    c1 = TOT_W'(bf3_q) + TOT_W'(ss3_q);
    c2 = TOT_W'(bs3_q) + TOT_W'(fs3_q);
  end

  // Stage 5: overall best and the result on the last sample.
  always_comb begin
    upd5   = ctl4_q.vld & ctl4_q.fits & ctl4_q.past;
    short5 = !ctl4_q.fits | !ctl4_q.past;
    bt_d   = bt_q;
    if (upd5 && (ctl4_q.at_total || c4_q > bt_q)) bt_d = c4_q;
    res_vld_o       = ctl4_q.vld & ctl4_q.last;
    res_o.too_short = short5;
    res_o.best_sum  = short5 ? '0 : mtws_pkg::OUT_W'(bt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bf_q   <= '0;
      bs_q   <= '0;
      bt_q   <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl3_q <= ctl_i;
      ctl4_q <= ctl3_q;
      if (ctl_i.vld) begin
        bf_q <= ctl_i.last ? '0 : bf_d;
        bs_q <= ctl_i.last ? '0 : bs_d;
      end
      if (ctl4_q.vld) begin
        bt_q <= ctl4_q.last ? '0 : bt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bf3_q <= bf_d;
    bs3_q <= bs_d;
    fs3_q <= fs_now_i;
    ss3_q <= ss_now_i;
    c4_q  <= (c1 > c2) ? c1 : c2;
  end

endmodule

// ===== hdl/mtws_outq.sv =====
module mtws_outq #(
  parameter int unsigned DEPTH = mtws_pkg::RES_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtws_pkg::out_t data_i,
  output logic           valid_o,
  input  logic           stall_i,
  output mtws_pkg::out_t data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtws_pkg::out_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o & !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/max_two_disjoint_window_sums_unit.sv =====
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   mtws_pkg::in_t  (sample, last)
// out      output     out_valid_o / out_stall_i mtws_pkg::out_t (best_sum, too_short)
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One sample per cycle, sustained while in_stall_o is low; the rate is set by
// the three history reads per sample, served by one two-port and one one-port
// history RAM. A result is offered through an 8-entry result queue once its
// last sample has passed the window and best-pair stages.
// Reset is asynchronous: lengths return to 1, counters and sums clear; the
// history RAM is not cleared, entries are only read after being written.
// in_stall_o rises only while 8 results are owed to the output side.
`include "assert_macros.svh"

module max_two_disjoint_window_sums_unit #(
  parameter int unsigned MAX_LEN = mtws_pkg::MAX_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mtws_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mtws_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [mtws_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtws_pkg::LEN_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SUM_W = mtws_pkg::SAMPLE_W + $clog2(MAX_LEN);
  localparam int unsigned RSV_W = $clog2(mtws_pkg::RES_DEPTH + 1);

  logic [mtws_pkg::LEN_W-1:0] first_len_q, second_len_q;
  logic [RSV_W-1:0]           rsv_q;
  logic                       in_acc, out_acc, res_vld;
  mtws_pkg::ctl_t             ctl2;
  mtws_pkg::out_t             res;
  logic signed [SUM_W-1:0]    fs_now, ss_now, fs_lag, ss_lag;

  assign in_stall_o = rsv_q == RSV_W'(mtws_pkg::RES_DEPTH);
  assign in_acc     = in_valid_i & !in_stall_o;
  assign out_acc    = out_valid_o & !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= mtws_pkg::LEN_W'(1);
      second_len_q <= mtws_pkg::LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtws_pkg::REG_FIRST_LEN:  first_len_q  <= cfg_wdata_i;
        mtws_pkg::REG_SECOND_LEN: second_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Reserve a queue slot for every last sample taken; release it on delivery.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_q <= '0;
    end else if (in_acc && in_data_i.last && !out_acc) begin
      rsv_q <= rsv_q + RSV_W'(1);
    end else if (out_acc && !(in_acc && in_data_i.last)) begin
      rsv_q <= rsv_q - RSV_W'(1);
    end
  end

  mtws_window #(
    .MAX_LEN(MAX_LEN),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .in_i        (in_data_i),
    .first_len_i (first_len_q),
    .second_len_i(second_len_q),
    .ctl_o       (ctl2),
    .fs_now_o    (fs_now),
    .ss_now_o    (ss_now),
    .fs_lag_o    (fs_lag),
    .ss_lag_o    (ss_lag)
  );

  mtws_best #(
    .SUM_W(SUM_W)
  ) u_best (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl2),
    .fs_now_i (fs_now),
    .ss_now_i (ss_now),
    .fs_lag_i (fs_lag),
    .ss_lag_i (ss_lag),
    .res_vld_o(res_vld),
    .res_o    (res)
  );

  mtws_outq #(
    .DEPTH(mtws_pkg::RES_DEPTH)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_vld),
    .data_i (res),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_data_o)
  );

  `ASSERT_IMPL(a_out_reserved, out_valid_o, rsv_q != '0, "queued result has no reservation")
  `ASSERT_IMPL(a_push_reserved, res_vld, rsv_q != '0, "result produced without a reservation")
  `ASSERT_NEXT(a_last_reserves, in_acc && in_data_i.last, rsv_q != '0, "last sample left no reservation")

endmodule
